### rtl/core/lsce_pkg.sv
// shared types and constants for the line segment corner extractor
`default_nettype none
package lsce_pkg;

   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [14:0] SIN_B = 15'd21024;
   localparam logic [11:0] SIN_C = 12'd2320;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam logic [5:0] DIV_STEPS = 6'd47;

   localparam logic [1:0] CSR_ANGLE_MIN = 2'd0;
   localparam logic [1:0] CSR_DIST_SQ = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_MIN = 2'd2;

   localparam logic [2:0] PT_I_START = 3'd0;
   localparam logic [2:0] PT_I_END = 3'd1;
   localparam logic [2:0] PT_J_START = 3'd2;
   localparam logic [2:0] PT_J_END = 3'd3;
   localparam logic [2:0] PT_ORIGIN = 3'd4;
   localparam logic [2:0] PT_COUNT = 3'd5;

   typedef struct packed {
      logic [15:0] seg_angle;
      logic signed [15:0] seg_radius;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
      logic last_segment;
   } req_type;

   typedef struct packed {
      logic corner_found;
      logic signed [15:0] corner_x;
      logic signed [15:0] corner_y;
      logic last_corner;
   } rsp_type;

   typedef struct packed {
      logic [15:0] angle;
      logic signed [15:0] radius;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
   } seg_type;

   typedef struct packed {
      logic [14:0] angle_min;
      logic [31:0] dist_sq;
      logic [31:0] origin_min;
   } cfg_type;

   typedef enum logic [1:0] {
      SIN_SI = 2'd0,
      SIN_CI = 2'd1,
      SIN_SJ = 2'd2,
      SIN_CJ = 2'd3
   } sin_sel_type;

   typedef enum logic [3:0] {
      MUL_NONE  = 4'd0,
      MUL_CI_SJ = 4'd1,
      MUL_SI_CJ = 4'd2,
      MUL_RI_SJ = 4'd3,
      MUL_RJ_SI = 4'd4,
      MUL_RJ_CI = 4'd5,
      MUL_RI_CJ = 4'd6,
      MUL_DX    = 4'd7,
      MUL_DY    = 4'd8
   } mul_sel_type;

   typedef enum logic [3:0] {
      ACC_NONE    = 4'd0,
      ACC_DET_SET = 4'd1,
      ACC_DET_SUB = 4'd2,
      ACC_NX_SET  = 4'd3,
      ACC_NX_SUB  = 4'd4,
      ACC_NY_SET  = 4'd5,
      ACC_NY_SUB  = 4'd6,
      ACC_SUM_SET = 4'd7,
      ACC_SUM_ADD = 4'd8
   } acc_op_type;

   typedef enum logic [1:0] {
      OUT_NONE  = 2'd0,
      OUT_MID   = 2'd1,
      OUT_LAST  = 2'd2,
      OUT_EMPTY = 2'd3
   } out_op_type;

   typedef struct packed {
      logic wr_en;
      logic load_i;
      logic load_j;
      logic sin_feed;
      sin_sel_type sin_sel;
      mul_sel_type mul_sel;
      logic [2:0] pt;
      acc_op_type acc_op;
      logic eval_en;
      logic [2:0] eval_pt;
      logic div_start;
      logic div_sel_y;
      logic cap_x;
      logic cap_y;
      logic pend_load;
      out_op_type out_op;
   } cmd_type;

   typedef struct packed {
      logic angle_ok;
      logic det_zero;
      logic div_done;
      logic div_ok;
      logic corner_ok;
   } sts_type;

endpackage
`default_nettype wire

### rtl/core/line_segment_corner_extractor.sv
// top level: config registers, controller and datapath of the corner extractor
//
//  port group   dir   handshake                 payload
//  req_         in    start & !busy             req_data (lsce_pkg::req_type)
//  rsp_         out   rsp_strobe, one cycle     rsp_data (lsce_pkg::rsp_type)
//  csr_         in    csr_valid & csr_ready     csr_index, csr_wdata
//
// a non-final segment is stored while idle and leaves busy low.
// after the final segment each pair i<j is searched in turn, with the 47-step
// divider run up to twice per pair; a pair skipped on angle goes to the next pair.
// reset sets control state and config defaults; the segment store needs no clearing.
// results cannot be stalled: each is driven for exactly one cycle.
`default_nettype none
module line_segment_corner_extractor #(
   parameter int MAX_SEGMENTS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire lsce_pkg::req_type req_data,
   output logic rsp_strobe,
   output lsce_pkg::rsp_type rsp_data,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [31:0] csr_wdata
);

   lsce_pkg::cfg_type cfg_ff;
   lsce_pkg::cmd_type cmd;
   lsce_pkg::sts_type sts;
   logic [$clog2(MAX_SEGMENTS)-1:0] rd_addr, wr_addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_min <= 15'd4096;
         cfg_ff.dist_sq <= 32'd250000;
         cfg_ff.origin_min <= 32'd10000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lsce_pkg::CSR_ANGLE_MIN: cfg_ff.angle_min <= csr_wdata[14:0];
            lsce_pkg::CSR_DIST_SQ: cfg_ff.dist_sq <= csr_wdata;
            lsce_pkg::CSR_ORIGIN_MIN: cfg_ff.origin_min <= csr_wdata;
            default: ;
         endcase
      end
   end

   lsce_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .last_segment(req_data.last_segment),
      .busy(busy),
      .sts(sts),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr)
   );

   lsce_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .req(req_data),
      .cfg(cfg_ff),
      .sts(sts),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

### rtl/core/lsce_sin.sv
// four stage pipelined q1.15 sine from a binary angle
`default_nettype none
module lsce_sin (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic [15:0] angle,
   output logic out_valid,
   output logic signed [15:0] value
);

   logic [1:0] q;
   logic [14:0] z0;
   logic [29:0] zz;
   logic [26:0] cz;
   logic [29:0] tz;
   logic [30:0] uz;
   logic [15:0] vv;
   logic [14:0] vc;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [14:0] z1_ff, z2_ff, z3_ff;
   logic [14:0] zsq1_ff, zsq2_ff;
   logic n1_ff, n2_ff, n3_ff;
   logic [14:0] t2_ff;
   logic [15:0] u3_ff;
   logic signed [15:0] val_ff;

   assign q = angle[15:14];
   assign z0 = q[0] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
   assign zz = {15'd0, z0} * {15'd0, z0};
   assign cz = 27'(lsce_pkg::SIN_C) * 27'(zsq1_ff);
   assign tz = 30'(t2_ff) * 30'(zsq2_ff);
   assign uz = 31'(u3_ff) * 31'(z3_ff);
   assign vv = 16'(uz >> 14);
   assign vc = vv[15] ? 15'h7fff : vv[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      z1_ff <= z0;
      zsq1_ff <= 15'(zz >> 14);
      n1_ff <= q[1];
      z2_ff <= z1_ff;
      zsq2_ff <= zsq1_ff;
      n2_ff <= n1_ff;
      t2_ff <= lsce_pkg::SIN_B - 15'(cz >> 14);
      z3_ff <= z2_ff;
      n3_ff <= n2_ff;
      u3_ff <= lsce_pkg::SIN_A - 16'(tz >> 14);
      val_ff <= n3_ff ? -$signed({1'b0, vc}) : $signed({1'b0, vc});
   end

   assign out_valid = v4_ff;
   assign value = val_ff;

endmodule
`default_nettype wire

### rtl/core/lsce_div.sv
// restoring divider for the rounded intersection coordinate
`default_nettype none
module lsce_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic done,
   output logic ok,
   output logic signed [15:0] quo
);

   logic [31:0] nabs, dabs;
   logic [32:0] trial;
   logic ge;
   logic [16:0] qneg;

   logic busy_ff, done_ff, neg_ff, ovf_ff;
   logic [5:0] cnt_ff;
   logic [46:0] n_ff;
   logic [31:0] rem_ff, den_ff;
   logic [16:0] q_ff;

   assign nabs = num[31] ? (~num + 32'd1) : num;
   assign dabs = den[31] ? (~den + 32'd1) : den;
   assign trial = {rem_ff, n_ff[46]};
   assign ge = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= lsce_pkg::DIV_STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         // bias by half the divisor so truncation rounds half away from zero
         n_ff <= {nabs, 15'd0} + 47'(dabs >> 1);
         den_ff <= dabs;
         rem_ff <= '0;
         q_ff <= '0;
         ovf_ff <= 1'b0;
         neg_ff <= num[31] ^ den[31];
      end else if (busy_ff) begin
         rem_ff <= ge ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         q_ff <= {q_ff[15:0], ge};
         ovf_ff <= ovf_ff | q_ff[16];
         n_ff <= {n_ff[45:0], 1'b0};
      end
   end

   assign qneg = ~q_ff + 17'd1;
   assign done = done_ff;
   assign ok = !ovf_ff && (neg_ff ? (q_ff <= 17'd32768) : (q_ff <= 17'd32767));
   assign quo = neg_ff ? qneg[15:0] : q_ff[15:0];

endmodule
`default_nettype wire

### rtl/core/lsce_dp.sv
// datapath: segment store, sine pipe, shared multiplier, divider, output register
`default_nettype none
module lsce_dp #(
   parameter int MAX_SEGMENTS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire lsce_pkg::cmd_type cmd,
   input  wire logic [$clog2(MAX_SEGMENTS)-1:0] rd_addr,
   input  wire logic [$clog2(MAX_SEGMENTS)-1:0] wr_addr,
   input  wire lsce_pkg::req_type req,
   input  wire lsce_pkg::cfg_type cfg,
   output lsce_pkg::sts_type sts,
   output logic rsp_strobe,
   output lsce_pkg::rsp_type rsp_data
);

   lsce_pkg::seg_type mem_ff [MAX_SEGMENTS];
   lsce_pkg::seg_type rd_ff, seg_i_ff, seg_j_ff;
   logic signed [15:0] sv_ff [4];
   logic signed [35:0] prod_ff;
   logic signed [31:0] det_ff, nx_ff, ny_ff;
   logic [33:0] sum_ff;
   logic e_i_ff, e_j_ff, org_ff;
   logic signed [15:0] x_ff, y_ff, pend_x_ff, pend_y_ff;
   logic strobe_ff;
   lsce_pkg::rsp_type rsp_ff;

   logic [15:0] sin_angle;
   logic sin_vld;
   logic signed [15:0] sin_val;
   logic signed [17:0] mul_a, mul_b;
   logic signed [15:0] px, py;
   logic signed [16:0] dx, dy;
   logic signed [31:0] p32;
   logic [15:0] ad;
   logic [16:0] af1, af2;
   logic near, far;
   logic div_done, div_ok;
   logic signed [15:0] div_quo;

   // sine pipe
   always_comb begin
      case (cmd.sin_sel)
         lsce_pkg::SIN_SI: sin_angle = seg_i_ff.angle;
         lsce_pkg::SIN_CI: sin_angle = seg_i_ff.angle + lsce_pkg::QUARTER_TURN;
         lsce_pkg::SIN_SJ: sin_angle = seg_j_ff.angle;
         lsce_pkg::SIN_CJ: sin_angle = seg_j_ff.angle + lsce_pkg::QUARTER_TURN;
         default: sin_angle = seg_i_ff.angle;
      endcase
   end

   lsce_sin u_sin (
      .clock(clock),
      .reset(reset),
      .in_valid(cmd.sin_feed),
      .angle(sin_angle),
      .out_valid(sin_vld),
      .value(sin_val)
   );

   // folded angle difference
   assign ad = (seg_i_ff.angle >= seg_j_ff.angle) ? (seg_i_ff.angle - seg_j_ff.angle)
                                                  : (seg_j_ff.angle - seg_i_ff.angle);
   assign af1 = ({1'b0, ad} > 17'd32768) ? (17'd65536 - {1'b0, ad}) : {1'b0, ad};
   assign af2 = (af1 > 17'd16384) ? (17'd32768 - af1) : af1;

   // endpoint select for the distance checks
   always_comb begin
      case (cmd.pt)
         lsce_pkg::PT_I_START: begin
            px = seg_i_ff.sx;
            py = seg_i_ff.sy;
         end
         lsce_pkg::PT_I_END: begin
            px = seg_i_ff.ex;
            py = seg_i_ff.ey;
         end
         lsce_pkg::PT_J_START: begin
            px = seg_j_ff.sx;
            py = seg_j_ff.sy;
         end
         lsce_pkg::PT_J_END: begin
            px = seg_j_ff.ex;
            py = seg_j_ff.ey;
         end
         default: begin
            px = '0;
            py = '0;
         end
      endcase
   end

   assign dx = {px[15], px} - {x_ff[15], x_ff};
   assign dy = {py[15], py} - {y_ff[15], y_ff};

   // sv_ff[3..0] hold si, ci, sj, cj
   always_comb begin
      case (cmd.mul_sel)
         lsce_pkg::MUL_CI_SJ: begin
            mul_a = 18'(sv_ff[2]);
            mul_b = 18'(sv_ff[1]);
         end
         lsce_pkg::MUL_SI_CJ: begin
            mul_a = 18'(sv_ff[3]);
            mul_b = 18'(sv_ff[0]);
         end
         lsce_pkg::MUL_RI_SJ: begin
            mul_a = 18'(seg_i_ff.radius);
            mul_b = 18'(sv_ff[1]);
         end
         lsce_pkg::MUL_RJ_SI: begin
            mul_a = 18'(seg_j_ff.radius);
            mul_b = 18'(sv_ff[3]);
         end
         lsce_pkg::MUL_RJ_CI: begin
            mul_a = 18'(seg_j_ff.radius);
            mul_b = 18'(sv_ff[2]);
         end
         lsce_pkg::MUL_RI_CJ: begin
            mul_a = 18'(seg_i_ff.radius);
            mul_b = 18'(sv_ff[0]);
         end
         lsce_pkg::MUL_DX: begin
            mul_a = 18'(dx);
            mul_b = 18'(dx);
         end
         lsce_pkg::MUL_DY: begin
            mul_a = 18'(dy);
            mul_b = 18'(dy);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign p32 = prod_ff[31:0];
   assign near = sum_ff < {2'b00, cfg.dist_sq};
   assign far = sum_ff > {2'b00, cfg.origin_min};

   lsce_div u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .num(cmd.div_sel_y ? ny_ff : nx_ff),
      .den(det_ff),
      .done(div_done),
      .ok(div_ok),
      .quo(div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= '{angle: req.seg_angle, radius: req.seg_radius,
                              sx: req.start_x, sy: req.start_y,
                              ex: req.end_x, ey: req.end_y};
      end
      rd_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_i) seg_i_ff <= rd_ff;
      if (cmd.load_j) seg_j_ff <= rd_ff;
      if (sin_vld) begin
         sv_ff[3] <= sv_ff[2];
         sv_ff[2] <= sv_ff[1];
         sv_ff[1] <= sv_ff[0];
         sv_ff[0] <= sin_val;
      end
      prod_ff <= mul_a * mul_b;
      case (cmd.acc_op)
         lsce_pkg::ACC_DET_SET: det_ff <= p32;
         lsce_pkg::ACC_DET_SUB: det_ff <= det_ff - p32;
         lsce_pkg::ACC_NX_SET: nx_ff <= p32;
         lsce_pkg::ACC_NX_SUB: nx_ff <= nx_ff - p32;
         lsce_pkg::ACC_NY_SET: ny_ff <= p32;
         lsce_pkg::ACC_NY_SUB: ny_ff <= ny_ff - p32;
         lsce_pkg::ACC_SUM_SET: sum_ff <= prod_ff[33:0];
         lsce_pkg::ACC_SUM_ADD: sum_ff <= sum_ff + prod_ff[33:0];
         default: ;
      endcase
      if (cmd.load_i) begin
         e_i_ff <= 1'b0;
         e_j_ff <= 1'b0;
         org_ff <= 1'b0;
      end else if (cmd.eval_en) begin
         case (cmd.eval_pt)
            lsce_pkg::PT_I_START, lsce_pkg::PT_I_END: e_i_ff <= e_i_ff | near;
            lsce_pkg::PT_J_START, lsce_pkg::PT_J_END: e_j_ff <= e_j_ff | near;
            default: org_ff <= far;
         endcase
      end
      if (cmd.cap_x && div_done) x_ff <= div_quo;
      if (cmd.cap_y && div_done) y_ff <= div_quo;
      if (cmd.pend_load) begin
         pend_x_ff <= x_ff;
         pend_y_ff <= y_ff;
      end
      case (cmd.out_op)
         lsce_pkg::OUT_MID: rsp_ff <= '{corner_found: 1'b1, corner_x: pend_x_ff,
                                        corner_y: pend_y_ff, last_corner: 1'b0};
         lsce_pkg::OUT_LAST: rsp_ff <= '{corner_found: 1'b1, corner_x: pend_x_ff,
                                         corner_y: pend_y_ff, last_corner: 1'b1};
         lsce_pkg::OUT_EMPTY: rsp_ff <= '{corner_found: 1'b0, corner_x: 16'sd0,
                                          corner_y: 16'sd0, last_corner: 1'b1};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= cmd.out_op != lsce_pkg::OUT_NONE;
   end

   assign sts.angle_ok = af2 >= {2'b00, cfg.angle_min};
   assign sts.det_zero = det_ff == 32'sd0;
   assign sts.div_done = div_done;
   assign sts.div_ok = div_ok;
   assign sts.corner_ok = e_i_ff & e_j_ff & org_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

### rtl/core/lsce_ctrl.sv
// controller: segment loading and the pairwise corner search sequence
`default_nettype none
module lsce_ctrl #(
   parameter int MAX_SEGMENTS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic last_segment,
   output logic busy,
   input  wire lsce_pkg::sts_type sts,
   output lsce_pkg::cmd_type cmd,
   output logic [$clog2(MAX_SEGMENTS)-1:0] rd_addr,
   output logic [$clog2(MAX_SEGMENTS)-1:0] wr_addr
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_RDI   = 16'h0002,
      S_RDJ   = 16'h0004,
      S_LDJ   = 16'h0008,
      S_ANG   = 16'h0010,
      S_SIN   = 16'h0020,
      S_MUL   = 16'h0040,
      S_DETC  = 16'h0080,
      S_DIVX  = 16'h0100,
      S_WAITX = 16'h0200,
      S_DIVY  = 16'h0400,
      S_WAITY = 16'h0800,
      S_DIST  = 16'h1000,
      S_EMIT  = 16'h2000,
      S_NEXT  = 16'h4000,
      S_DONE  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_seg_ff, cnt_seg_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] pt_ff, pt_in;
   logic [1:0] ph_ff, ph_in;
   logic pend_ff, pend_in;
   logic accept, full;
   logic [CW-1:0] cnt_new, j_next, i_next2;

   assign accept = start && (state_ff == S_IDLE);
   assign full = cnt_seg_ff == CW'(MAX_SEGMENTS);
   assign cnt_new = full ? cnt_seg_ff : cnt_seg_ff + 1'b1;
   assign j_next = CW'(j_ff) + 1'b1;
   assign i_next2 = CW'(i_ff) + CW'(2);

   always_comb begin
      state_in = state_ff;
      cnt_seg_in = cnt_seg_ff;
      i_in = i_ff;
      j_in = j_ff;
      step_in = step_ff;
      pt_in = pt_ff;
      ph_in = ph_ff;
      pend_in = pend_ff;
      cmd = '0;
      rd_addr = i_ff;
      wr_addr = cnt_seg_ff[IW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.wr_en = !full;
               cnt_seg_in = cnt_new;
               if (last_segment) begin
                  i_in = '0;
                  j_in = IW'(1);
                  state_in = (cnt_new >= CW'(2)) ? S_RDI : S_DONE;
               end
            end
         end
         S_RDI: state_in = S_RDJ;
         S_RDJ: begin
            rd_addr = j_ff;
            cmd.load_i = 1'b1;
            state_in = S_LDJ;
         end
         S_LDJ: begin
            cmd.load_j = 1'b1;
            state_in = S_ANG;
         end
         S_ANG: begin
            step_in = '0;
            state_in = sts.angle_ok ? S_SIN : S_NEXT;
         end
         S_SIN: begin
            // four feeds, then drain the four stage pipe
            cmd.sin_feed = !step_ff[2];
            case (step_ff[1:0])
               2'd0: cmd.sin_sel = lsce_pkg::SIN_SI;
               2'd1: cmd.sin_sel = lsce_pkg::SIN_CI;
               2'd2: cmd.sin_sel = lsce_pkg::SIN_SJ;
               default: cmd.sin_sel = lsce_pkg::SIN_CJ;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) state_in = S_MUL;
         end
         S_MUL: begin
            case (step_ff)
               3'd0: cmd.mul_sel = lsce_pkg::MUL_CI_SJ;
               3'd1: begin
                  cmd.mul_sel = lsce_pkg::MUL_SI_CJ;
                  cmd.acc_op = lsce_pkg::ACC_DET_SET;
               end
               3'd2: begin
                  cmd.mul_sel = lsce_pkg::MUL_RI_SJ;
                  cmd.acc_op = lsce_pkg::ACC_DET_SUB;
               end
               3'd3: begin
                  cmd.mul_sel = lsce_pkg::MUL_RJ_SI;
                  cmd.acc_op = lsce_pkg::ACC_NX_SET;
               end
               3'd4: begin
                  cmd.mul_sel = lsce_pkg::MUL_RJ_CI;
                  cmd.acc_op = lsce_pkg::ACC_NX_SUB;
               end
               3'd5: begin
                  cmd.mul_sel = lsce_pkg::MUL_RI_CJ;
                  cmd.acc_op = lsce_pkg::ACC_NY_SET;
               end
               default: cmd.acc_op = lsce_pkg::ACC_NY_SUB;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) state_in = S_DETC;
         end
         S_DETC: state_in = sts.det_zero ? S_NEXT : S_DIVX;
         S_DIVX: begin
            cmd.div_start = 1'b1;
            state_in = S_WAITX;
         end
         S_WAITX: begin
            cmd.cap_x = 1'b1;
            if (sts.div_done) state_in = sts.div_ok ? S_DIVY : S_NEXT;
         end
         S_DIVY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in = S_WAITY;
         end
         S_WAITY: begin
            cmd.cap_y = 1'b1;
            pt_in = '0;
            ph_in = '0;
            if (sts.div_done) state_in = sts.div_ok ? S_DIST : S_NEXT;
         end
         S_DIST: begin
            // per point: square dx, square dy, add; compare overlaps next point
            cmd.pt = pt_ff;
            cmd.eval_pt = pt_ff - 3'd1;
            case (ph_ff)
               2'd0: begin
                  cmd.eval_en = pt_ff != 3'd0;
                  if (pt_ff == lsce_pkg::PT_COUNT) begin
                     state_in = S_EMIT;
                  end else begin
                     cmd.mul_sel = lsce_pkg::MUL_DX;
                     ph_in = 2'd1;
                  end
               end
               2'd1: begin
                  cmd.mul_sel = lsce_pkg::MUL_DY;
                  cmd.acc_op = lsce_pkg::ACC_SUM_SET;
                  ph_in = 2'd2;
               end
               default: begin
                  cmd.acc_op = lsce_pkg::ACC_SUM_ADD;
                  ph_in = 2'd0;
                  pt_in = pt_ff + 3'd1;
               end
            endcase
         end
         S_EMIT: begin
            // hold one corner back so the final one can carry last_corner
            if (sts.corner_ok) begin
               cmd.pend_load = 1'b1;
               cmd.out_op = pend_ff ? lsce_pkg::OUT_MID : lsce_pkg::OUT_NONE;
               pend_in = 1'b1;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (j_next < cnt_seg_ff) begin
               j_in = j_next[IW-1:0];
               state_in = S_RDI;
            end else if (i_next2 < cnt_seg_ff) begin
               i_in = i_ff + 1'b1;
               j_in = i_next2[IW-1:0];
               state_in = S_RDI;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.out_op = pend_ff ? lsce_pkg::OUT_LAST : lsce_pkg::OUT_EMPTY;
            pend_in = 1'b0;
            cnt_seg_in = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_seg_ff <= '0;
         pend_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         step_ff <= '0;
         pt_ff <= '0;
         ph_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_seg_ff <= cnt_seg_in;
         pend_ff <= pend_in;
         i_ff <= i_in;
         j_ff <= j_in;
         step_ff <= step_in;
         pt_ff <= pt_in;
         ph_ff <= ph_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   a_seg_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_seg_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count above capacity");

   a_not_last_stays_idle: assert property (@(posedge clock) disable iff (reset)
      accept && !last_segment |=> state_ff == S_IDLE)
      else $error("non-final segment started a search");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE && state_ff != S_DONE |-> j_ff > i_ff)
      else $error("pair indices out of order");

   a_pair_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE && state_ff != S_DONE |-> CW'(j_ff) < cnt_seg_ff)
      else $error("pair index beyond loaded segments");

endmodule
`default_nettype wire

### tb/tb_line_segment_corner_extractor.sv
// testbench for the line segment corner extractor: predicted corners vs block output
`timescale 1ns / 1ps
`default_nettype none
module tb_line_segment_corner_extractor;

   localparam int MAX_SEG = 8;

   class corner_scoreboard;
      logic [14:0] angle_min;
      logic [31:0] dist_sq;
      logic [31:0] origin_min;
      lsce_pkg::seg_type segs[MAX_SEG];
      int seg_count;
      lsce_pkg::rsp_type pending_corners[$];
      int mismatches;

      function void clear();
         angle_min = 15'd4096;
         dist_sq = 32'd250000;
         origin_min = 32'd10000;
         seg_count = 0;
         mismatches = 0;
         pending_corners.delete();
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         if (idx == lsce_pkg::CSR_ANGLE_MIN) angle_min = val[14:0];
         else if (idx == lsce_pkg::CSR_DIST_SQ) dist_sq = val;
         else if (idx == lsce_pkg::CSR_ORIGIN_MIN) origin_min = val;
      endfunction

      function int sin_q15(logic [15:0] a);
         logic [1:0] q;
         logic [31:0] z, z2, t, v;
         q = a[15:14];
         z = q[0] ? 32'd16384 - a[13:0] : {18'd0, a[13:0]};
         z2 = (z * z) >> 14;
         t = (32'd2320 * z2) >> 14;
         t = 32'd21024 - t;
         t = (t * z2) >> 14;
         t = 32'd51472 - t;
         v = (t * z) >> 14;
         if (v > 32767) v = 32767;
         return q[1] ? -int'(v) : int'(v);
      endfunction

      // rounded quotient in mm, 0 when out of 16-bit range
      function bit divide_mm(longint num, longint det, output int res);
         longint unsigned n, d, q;
         bit neg;
         n = num < 0 ? -num : num;
         d = det < 0 ? -det : det;
         neg = (num < 0) != (det < 0);
         n = n << 15;
         q = (n + d / 2) / d;
         if (neg) begin
            if (q > 32768) return 0;
            res = -int'(q);
         end else begin
            if (q > 32767) return 0;
            res = int'(q);
         end
         return 1;
      endfunction

      function bit near(int px, int py, int x, int y);
         longint dx, dy;
         dx = px - x;
         dy = py - y;
         return longint'(dx * dx + dy * dy) < longint'({32'd0, dist_sq});
      endfunction

      function void note_request(lsce_pkg::req_type r);
         int si, ci, sj, cj, d, x, y, found;
         longint det, nx, ny, od;
         bit e1, e2;
         lsce_pkg::rsp_type c;
         if (seg_count < MAX_SEG) begin
            segs[seg_count] = '{r.seg_angle, r.seg_radius, r.start_x, r.start_y,
                                r.end_x, r.end_y};
            seg_count++;
         end
         if (!r.last_segment) return;
         found = 0;
         for (int i = 0; i < seg_count; i++) begin
            si = sin_q15(segs[i].angle);
            ci = sin_q15(segs[i].angle + 16'd16384);
            for (int j = i + 1; j < seg_count; j++) begin
               sj = sin_q15(segs[j].angle);
               cj = sin_q15(segs[j].angle + 16'd16384);
               d = int'(segs[i].angle) - int'(segs[j].angle);
               if (d < 0) d = -d;
               if (d > 32768) d = 65536 - d;
               if (d > 16384) d = 32768 - d;
               if (d < int'(angle_min)) continue;
               det = longint'(ci) * sj - longint'(si) * cj;
               if (det == 0) continue;
               nx = longint'(segs[i].radius) * sj - longint'(segs[j].radius) * si;
               ny = longint'(segs[j].radius) * ci - longint'(segs[i].radius) * cj;
               if (!divide_mm(nx, det, x)) continue;
               if (!divide_mm(ny, det, y)) continue;
               e1 = near(segs[i].sx, segs[i].sy, x, y) || near(segs[i].ex, segs[i].ey, x, y);
               e2 = near(segs[j].sx, segs[j].sy, x, y) || near(segs[j].ex, segs[j].ey, x, y);
               od = longint'(x) * x + longint'(y) * y;
               if (e1 && e2 && od > longint'({32'd0, origin_min})) begin
                  c.corner_found = 1'b1;
                  c.corner_x = x[15:0];
                  c.corner_y = y[15:0];
                  c.last_corner = 1'b0;
                  pending_corners = {pending_corners, c};
                  found++;
               end
            end
         end
         seg_count = 0;
         if (found == 0) begin
            c = '{1'b0, 16'sd0, 16'sd0, 1'b1};
            pending_corners = {pending_corners, c};
         end else begin
            pending_corners[pending_corners.size() - 1].last_corner = 1'b1;
         end
      endfunction

      function void check_corner(lsce_pkg::rsp_type got);
         lsce_pkg::rsp_type want;
         if (pending_corners.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected corner %p", got);
            return;
         end
         want = pending_corners.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("corner mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lsce_pkg::req_type req_data = '0;
   logic rsp_strobe;
   lsce_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   corner_scoreboard sb = new();
   int idle_pct = 0;

   line_segment_corner_extractor dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_corner(rsp_data);
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // start stays high between back to back requests; idling and drain drop it
   task automatic send_segment(lsce_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending_corners.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   // segment on the given line, start endpoint near the corner point, end endpoint farther out
   function automatic lsce_pkg::req_type line_seg(logic [15:0] ang, int r, int cx, int cy,
                                                  bit last);
      lsce_pkg::req_type s;
      s.seg_angle = ang;
      s.seg_radius = 16'(r);
      s.start_x = 16'(cx + $urandom_range(200) - 100);
      s.start_y = 16'(cy + $urandom_range(200) - 100);
      s.end_x = 16'(cx + $urandom_range(4000) - 2000);
      s.end_y = 16'(cy + $urandom_range(4000) - 2000);
      s.last_segment = last;
      return s;
   endfunction

   task automatic corner_set(int n);
      int cx, cy, r;
      logic [15:0] a;
      real th;
      cx = $urandom_range(6000) - 3000;
      cy = $urandom_range(6000) - 3000;
      for (int k = 0; k < n; k++) begin
         a = 16'($urandom);
         th = real'(a) * 6.283185307 / 65536.0;
         r = int'(cx * $cos(th) + cy * $sin(th));
         send_segment(line_seg(a, r, cx, cy, k == n - 1));
      end
   endtask

   task automatic noise_set(int n);
      lsce_pkg::req_type s;
      for (int k = 0; k < n; k++) begin
         s = lsce_pkg::req_type'({$urandom, $urandom, $urandom, $urandom});
         s.last_segment = (k == n - 1);
         send_segment(s);
      end
   endtask

   initial begin
      lsce_pkg::req_type s;
      sb.clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, parallel lines, overflow, empty set, overfull store
      s = '{16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0};
      send_segment(s);
      s = '{16'hFFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1};
      send_segment(s);
      send_segment('{16'h4000, 16'sd500, 16'sd0, 16'sd500, 16'sd100, 16'sd500, 1'b0});
      send_segment('{16'h4000, 16'sd900, 16'sd0, 16'sd900, 16'sd100, 16'sd900, 1'b1});
      send_segment('{16'h0000, 16'sd1000, 16'sd1000, 16'sd0, 16'sd1000, 16'sd40, 1'b0});
      send_segment('{16'h4000, 16'sd1000, 16'sd0, 16'sd1000, 16'sd40, 16'sd1000, 1'b1});
      send_segment('{16'h0000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0});
      send_segment('{16'h0010, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1});
      send_segment('{16'h1234, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1});
      corner_set(11);
      drain();
      write_reg(lsce_pkg::CSR_ANGLE_MIN, 32'd0);
      write_reg(lsce_pkg::CSR_DIST_SQ, 32'hFFFF_FFFF);
      write_reg(lsce_pkg::CSR_ORIGIN_MIN, 32'd0);
      corner_set(8);
      drain();
      write_reg(lsce_pkg::CSR_ANGLE_MIN, 32'd16384);
      write_reg(lsce_pkg::CSR_ORIGIN_MIN, 32'hFFFF_FFFF);
      corner_set(4);
      drain();
      write_reg(lsce_pkg::CSR_ANGLE_MIN, 32'd16385);
      write_reg(lsce_pkg::CSR_ORIGIN_MIN, 32'd10000);
      corner_set(3);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 49 : (ph % 4 == 2) ? 0 : 23;
         write_reg(lsce_pkg::CSR_ANGLE_MIN, $urandom_range(ph == 7 ? 0 : 6000));
         write_reg(lsce_pkg::CSR_DIST_SQ,
                   (ph == 5) ? 32'd0 : $urandom_range(4000000, 100000));
         write_reg(lsce_pkg::CSR_ORIGIN_MIN, $urandom_range(200000));
         for (int k = 0; k < 11; k++) begin
            if ($urandom_range(9) < 8) corner_set($urandom_range(MAX_SEG + 2, 1));
            else noise_set($urandom_range(4, 1));
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.pending_corners.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
